>>> rtl/hbd_pkg.sv
// Shared types, codes and constants for the signed-duty H-bridge drive.
package hbd_pkg;

  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned COMPARE_W   = PERIOD_W + 1;
  localparam int unsigned MAG_W       = 8;
  localparam int unsigned PRODUCT_W   = MAG_W + PERIOD_W;
  localparam int unsigned RECIP_W     = 16;
  localparam int unsigned RECIP_SHIFT = 23;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [1:0] CMD_DUTY = 2'd0;
  localparam logic [1:0] CMD_DIR  = 2'd1;
  localparam logic [1:0] CMD_RAW  = 2'd2;

  localparam logic [1:0] DIR_CW    = 2'd0;
  localparam logic [1:0] DIR_CCW   = 2'd1;
  localparam logic [1:0] DIR_BRAKE = 2'd2;
  localparam logic [1:0] DIR_FREE  = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PWM    = 2'd1;

  localparam logic [PERIOD_W-1:0]  PERIOD_RESET = 16'd47999;
  localparam logic [COMPARE_W-1:0] ON_COUNT     = 17'd47999;
  localparam logic [MAG_W-1:0]     DUTY_FULL    = 8'd255;
  // 2^23 / 255 rounded up
  localparam logic [RECIP_W-1:0]   RECIP_255    = 16'h8081;

  typedef struct packed {
    logic [1:0]        command;
    logic signed [15:0] signed_duty;
    logic [1:0]        direction_request;
    logic [15:0]       raw_count;
  } in_beat_t;

  typedef struct packed {
    logic                 pin_a;
    logic                 pin_b;
    logic [1:0]           direction_now;
    logic [COMPARE_W-1:0] compare_count;
  } out_beat_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic                pwm;
  } cfg_t;

  typedef struct packed {
    logic [1:0]           command;
    logic                 neg;
    logic [1:0]           direction_request;
    logic [15:0]          raw_count;
    logic [PRODUCT_W-1:0] product;
  } mid_t;

endpackage

>>> rtl/hbd_scale.sv
// Duty magnitude, saturation and period product for one command beat.
module hbd_scale (
  input  hbd_pkg::in_beat_t        beat,
  input  logic [hbd_pkg::PERIOD_W-1:0] period,
  output hbd_pkg::mid_t            mid
);

  logic [16:0]                  abs_val;
  logic [hbd_pkg::MAG_W-1:0]    mag;

  always_comb begin
    if (beat.signed_duty[15]) begin
      abs_val = 17'h10000 - {1'b0, beat.signed_duty};
    end else begin
      abs_val = {1'b0, beat.signed_duty};
    end
    if (abs_val > {9'd0, hbd_pkg::DUTY_FULL}) begin
      mag = hbd_pkg::DUTY_FULL;
    end else begin
      mag = abs_val[hbd_pkg::MAG_W-1:0];
    end
    mid.command           = beat.command;
    mid.neg               = beat.signed_duty[15];
    mid.direction_request = beat.direction_request;
    mid.raw_count         = beat.raw_count;
    mid.product           = {{hbd_pkg::PERIOD_W{1'b0}}, mag}
                          * {{hbd_pkg::MAG_W{1'b0}}, period};
  end

endmodule

>>> rtl/hbd_update.sv
// Divide by 255, mode rules, stored direction and compare, result register.
module hbd_update (
  input  logic               clk,
  input  logic               rst_n,
  input  hbd_pkg::cfg_t      cfg,
  input  logic               mid_valid,
  input  hbd_pkg::mid_t      mid,
  output logic               take,
  output logic               out_valid,
  input  logic               out_ready,
  output hbd_pkg::out_beat_t out_data
);

  localparam int unsigned EST_W = hbd_pkg::PRODUCT_W + hbd_pkg::RECIP_W;
  localparam int unsigned CW    = hbd_pkg::COMPARE_W;

  logic [1:0]         dir_r, dir_nxt;
  logic [CW-1:0]      cmp_r, cmp_nxt;
  logic               out_valid_r;
  hbd_pkg::out_beat_t out_r;

  logic [EST_W-1:0]   est;
  logic [CW-1:0]      q_est;
  logic [CW+7:0]      back;
  logic [CW-1:0]      quot;
  logic [CW-1:0]      count;
  logic               apply;
  logic               fire;

  assign take      = !out_valid_r || out_ready;
  assign fire      = mid_valid && take;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    est   = {{hbd_pkg::RECIP_W{1'b0}}, mid.product}
          * {{hbd_pkg::PRODUCT_W{1'b0}}, hbd_pkg::RECIP_255};
    q_est = est[hbd_pkg::RECIP_SHIFT +: CW];
    back  = {q_est, 8'd0} - {8'd0, q_est};
    if (back > {1'b0, mid.product}) begin
      quot = q_est - CW'(1);
    end else begin
      quot = q_est;
    end
  end

  always_comb begin
    dir_nxt = dir_r;
    cmp_nxt = cmp_r;
    count   = {1'b0, mid.raw_count};
    apply   = 1'b0;
    case (mid.command)
      hbd_pkg::CMD_DUTY: begin
        dir_nxt = mid.neg ? hbd_pkg::DIR_CCW : hbd_pkg::DIR_CW;
        count   = quot;
        apply   = 1'b1;
      end
      hbd_pkg::CMD_DIR: begin
        dir_nxt = mid.direction_request;
      end
      hbd_pkg::CMD_RAW: begin
        apply   = 1'b1;
      end
      default: begin
      end
    endcase
    if (apply) begin
      if (cfg.pwm) begin
        if (count == {1'b0, cfg.period}) begin
          cmp_nxt = {1'b0, cfg.period} + CW'(1);
        end else begin
          cmp_nxt = count;
        end
      end else if (count != '0) begin
        cmp_nxt = hbd_pkg::ON_COUNT;
      end else begin
        cmp_nxt = '0;
        dir_nxt = hbd_pkg::DIR_FREE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      dir_r       <= hbd_pkg::DIR_FREE;
      cmp_r       <= '0;
    end else begin
      if (take) begin
        out_valid_r <= mid_valid;
      end
      if (fire) begin
        dir_r <= dir_nxt;
        cmp_r <= cmp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r.pin_a         <= (dir_nxt == hbd_pkg::DIR_CW) || (dir_nxt == hbd_pkg::DIR_BRAKE);
      out_r.pin_b         <= (dir_nxt == hbd_pkg::DIR_CCW) || (dir_nxt == hbd_pkg::DIR_BRAKE);
      out_r.direction_now <= dir_nxt;
      out_r.compare_count <= cmp_nxt;
    end
  end

endmodule

>>> rtl/signed_duty_hbridge_drive_top.sv
// Signed-duty H-bridge drive top: input stage, product stage, result stage.
// A beat passes the input, product and result registers in that order.
// Throughput: one beat per cycle while out_ready is high; the product register
// splits the duty multiply from the reciprocal divide by 255, and stored state
// updates in the result stage. Reset (synchronous, rst_n low): pipeline empty,
// direction FREE, compare 0, period 47999, PWM mode.
module signed_duty_hbridge_drive_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  hbd_pkg::in_beat_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output hbd_pkg::out_beat_t              out_data,
  input  logic                            cfg_we,
  input  logic [hbd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hbd_pkg::PERIOD_W-1:0]    cfg_wdata
);

  hbd_pkg::cfg_t     cfg_r;
  logic              valid_a_r;
  hbd_pkg::in_beat_t in_r;
  logic              valid_b_r;
  hbd_pkg::mid_t     mid_r, mid_nxt;
  logic              take;
  logic              a_go;

  assign a_go     = !valid_b_r || take;
  assign in_ready = !valid_a_r || a_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period <= hbd_pkg::PERIOD_RESET;
      cfg_r.pwm    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        hbd_pkg::CFG_PERIOD: cfg_r.period <= cfg_wdata;
        hbd_pkg::CFG_PWM:    cfg_r.pwm    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      valid_b_r <= 1'b0;
    end else begin
      if (in_ready) begin
        valid_a_r <= in_valid;
      end
      if (a_go) begin
        valid_b_r <= valid_a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
    if (a_go && valid_a_r) begin
      mid_r <= mid_nxt;
    end
  end

  hbd_scale u_scale (
    .beat   (in_r),
    .period (cfg_r.period),
    .mid    (mid_nxt)
  );

  hbd_update u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .mid_valid (valid_b_r),
    .mid       (mid_r),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_b_r && take) |=> out_valid)
    else $error("product stage beat did not reach result register");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready && valid_a_r && valid_b_r) |-> !in_ready)
    else $error("input accepted into a full stalled pipeline");

  a_pins_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.pin_a && out_data.pin_b) ==
                   (out_data.direction_now == hbd_pkg::DIR_BRAKE)))
    else $error("bridge pins disagree with direction");

  a_free_pins: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.direction_now == hbd_pkg::DIR_FREE)
      |-> (!out_data.pin_a && !out_data.pin_b))
    else $error("free direction drives a bridge pin");
`endif

endmodule
